// ----- hdl/y2rgb_pkg.sv -----
// Package for the YUY2 to RGB pair converter: request types, fixed-point
// coefficients and widths shared by the chroma, lane and top-level modules.
// No dependencies.
package y2rgb_pkg;

    localparam int SUM_W = 27;
    localparam int PIX_W = 8;

    localparam logic signed [SUM_W-1:0] COEF_V_RED   = 27'sd89831;
    localparam logic signed [SUM_W-1:0] COEF_V_GREEN = 27'sd45744;
    localparam logic signed [SUM_W-1:0] COEF_U_GREEN = 27'sd22127;
    localparam logic signed [SUM_W-1:0] COEF_U_BLUE  = 27'sd113538;

    localparam logic [PIX_W-1:0] CHAN_MAX  = 8'd255;
    localparam logic [PIX_W-1:0] SCALE_NUM = 8'd220;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] chroma_blue;
        logic [7:0] luma_second;
        logic [7:0] chroma_red;
        logic       frame_end;
    } yuy2_in_t;

    typedef struct packed {
        logic [7:0] red_first;
        logic [7:0] green_first;
        logic [7:0] blue_first;
        logic [7:0] red_second;
        logic [7:0] green_second;
        logic [7:0] blue_second;
        logic       frame_end_out;
    } rgb_pair_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] red;
        logic signed [SUM_W-1:0] green;
        logic signed [SUM_W-1:0] blue;
    } chroma_terms_t;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } rgb_t;

endpackage

// ----- hdl/yuy2_to_rgb_pair_converter.sv -----
// Top level of the YUY2 to RGB pair converter: three-stage pipeline with a
// shared chroma stage, two pixel lanes and a merging output register.
// Depends on y2rgb_pkg, y2rgb_chroma and y2rgb_lane.
//
//   channel   direction   handshake          payload
//   s_        in          s_valid/s_ready    yuy2_in_t  (one YUY2 word)
//   m_        out         m_valid/m_ready    rgb_pair_t (two RGB pixels)
//
// One request per cycle sustained while m_ready stays high; an accepted request
// passes the chroma multiply, clamp and output registers in turn, and m_valid
// rises once it is held in the output register.
// Each stage loads when empty or when the stage after it moves, so bubbles close
// up; with a stage empty, a request is taken while a result waits on m_ready.
// aresetn is synchronous, active low, and empties all stages.
module yuy2_to_rgb_pair_converter import y2rgb_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  yuy2_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output rgb_pair_t m_data
);

    logic          v1_reg;
    logic          v2_reg;
    logic          v3_reg;
    logic          rdy1;
    logic          rdy2;
    logic          rdy3;
    logic [7:0]    y0_reg;
    logic [7:0]    y1_reg;
    logic          fe1_reg;
    logic          fe2_reg;
    chroma_terms_t terms;
    rgb_t          pix0;
    rgb_t          pix1;
    rgb_pair_t     out_reg;
    rgb_pair_t     out_next;

    assign rdy3 = !v3_reg || m_ready;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign s_ready = rdy1;
    assign m_valid = v3_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            y0_reg  <= s_data.luma_first;
            y1_reg  <= s_data.luma_second;
            fe1_reg <= s_data.frame_end;
        end
        if (rdy2) begin
            fe2_reg <= fe1_reg;
        end
        if (rdy3) begin
            out_reg <= out_next;
        end
    end

    y2rgb_chroma u_chroma (
        .aclk        (aclk),
        .load        (rdy1),
        .chroma_blue (s_data.chroma_blue),
        .chroma_red  (s_data.chroma_red),
        .terms       (terms)
    );

    y2rgb_lane u_lane0 (
        .aclk  (aclk),
        .load  (rdy2),
        .luma  (y0_reg),
        .terms (terms),
        .pixel (pix0)
    );

    y2rgb_lane u_lane1 (
        .aclk  (aclk),
        .load  (rdy2),
        .luma  (y1_reg),
        .terms (terms),
        .pixel (pix1)
    );

    always_comb begin
        out_next.red_first     = pix0.red;
        out_next.green_first   = pix0.green;
        out_next.blue_first    = pix0.blue;
        out_next.red_second    = pix1.red;
        out_next.green_second  = pix1.green;
        out_next.blue_second   = pix1.blue;
        out_next.frame_end_out = fe2_reg;
    end

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.red_first <= 8'd219) && (m_data.green_first <= 8'd219)
            && (m_data.blue_first <= 8'd219) && (m_data.red_second <= 8'd219)
            && (m_data.green_second <= 8'd219) && (m_data.blue_second <= 8'd219))
        else $error("channel above scaled range");

    a_stage1: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v1_reg)
        else $error("accepted request lost at stage 1");

    a_stage2: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && rdy2) |=> v2_reg)
        else $error("request lost between stage 1 and 2");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && v2_reg && v3_reg && !m_ready) |-> !s_ready)
        else $error("request taken with full pipeline");

endmodule

// ----- hdl/y2rgb_chroma.sv -----
// Shared chroma stage: centers Cb/Cr and registers the per-channel chroma
// products used by both pixel lanes. Depends on y2rgb_pkg.
module y2rgb_chroma import y2rgb_pkg::*; (
    input  logic          aclk,
    input  logic          load,
    input  logic [7:0]    chroma_blue,
    input  logic [7:0]    chroma_red,
    output chroma_terms_t terms
);

    logic signed [8:0]       cb_c;
    logic signed [8:0]       cr_c;
    logic signed [SUM_W-1:0] cb_x;
    logic signed [SUM_W-1:0] cr_x;
    chroma_terms_t           terms_reg;
    chroma_terms_t           terms_next;

    always_comb begin
        cb_c = {~chroma_blue[7], ~chroma_blue[7], chroma_blue[6:0]};
        cr_c = {~chroma_red[7], ~chroma_red[7], chroma_red[6:0]};
        cb_x = SUM_W'(cb_c);
        cr_x = SUM_W'(cr_c);
        terms_next.red   = COEF_V_RED * cr_x;
        terms_next.green = COEF_V_GREEN * cr_x + COEF_U_GREEN * cb_x;
        terms_next.blue  = COEF_U_BLUE * cb_x;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            terms_reg <= terms_next;
        end
    end

    assign terms = terms_reg;

endmodule

// ----- hdl/y2rgb_lane.sv -----
// One pixel lane: adds the red and blue chroma terms to luma and subtracts the green
// term, clamps to 0..255 and registers, then scales by 220/256. Depends on y2rgb_pkg.
module y2rgb_lane import y2rgb_pkg::*; (
    input  logic          aclk,
    input  logic          load,
    input  logic [7:0]    luma,
    input  chroma_terms_t terms,
    output rgb_t          pixel
);

    logic signed [SUM_W-1:0] y_term;
    logic signed [SUM_W-1:0] sum_r;
    logic signed [SUM_W-1:0] sum_g;
    logic signed [SUM_W-1:0] sum_b;
    rgb_t                    clamp_reg;
    rgb_t                    clamp_next;
    logic [15:0]             scale_r;
    logic [15:0]             scale_g;
    logic [15:0]             scale_b;

    function automatic logic [PIX_W-1:0] clamp_chan(input logic signed [SUM_W-1:0] s);
        logic [PIX_W-1:0] c;
        if (s[SUM_W-1]) begin
            c = '0;
        end else if (|s[SUM_W-2:24]) begin
            c = CHAN_MAX;
        end else begin
            c = s[23:16];
        end
        return c;
    endfunction

    always_comb begin
        y_term = {3'b000, luma, 16'h0000};
        sum_r  = y_term + terms.red;
        sum_g  = y_term - terms.green;
        sum_b  = y_term + terms.blue;
        clamp_next.red   = clamp_chan(sum_r);
        clamp_next.green = clamp_chan(sum_g);
        clamp_next.blue  = clamp_chan(sum_b);
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            clamp_reg <= clamp_next;
        end
    end

    always_comb begin
        scale_r = clamp_reg.red * SCALE_NUM;
        scale_g = clamp_reg.green * SCALE_NUM;
        scale_b = clamp_reg.blue * SCALE_NUM;
        pixel.red   = scale_r[15:8];
        pixel.green = scale_g[15:8];
        pixel.blue  = scale_b[15:8];
    end

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for yuy2_to_rgb_pair_converter: drives YUY2 requests with
// random bursts and gaps, stalls the RGB side, and compares each result with a local
// fixed-point conversion. Depends on y2rgb_pkg for the request and result types.
module testbench import y2rgb_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RED_PER_CR   = 89831;
    localparam int GREEN_PER_CR = 45744;
    localparam int GREEN_PER_CB = 22127;
    localparam int BLUE_PER_CB  = 113538;
    localparam int CHROMA_ZERO  = 128;
    localparam int SWING_NUM    = 220;
    localparam int RANDOM_WORDS = 450;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 50;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    yuy2_in_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    rgb_pair_t m_data;

    yuy2_in_t  yuy2_words[$];
    rgb_pair_t rgb_expected[$];

    bit req_accepted   = 1'b0;
    int gap_left       = 0;
    int burst_left     = 1;
    int ready_mode     = 0;
    int ready_tick     = 0;
    int mismatch_count = 0;
    int result_count   = 0;
    int cycle_count    = 0;

    yuy2_to_rgb_pair_converter i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [7:0] clamp_and_scale(int fixed_sum);
        int whole;
        if (fixed_sum < 0) begin
            whole = 0;
        end else begin
            whole = fixed_sum >>> 16;
            if (whole > 255) begin
                whole = 255;
            end
        end
        return 8'((whole * SWING_NUM) >> 8);
    endfunction

    function automatic rgb_pair_t convert_yuy2_pair(yuy2_in_t word);
        rgb_pair_t pair;
        int        cb;
        int        cr;
        int        base0;
        int        base1;
        cb    = int'(word.chroma_blue) - CHROMA_ZERO;
        cr    = int'(word.chroma_red) - CHROMA_ZERO;
        base0 = int'(word.luma_first) * 65536;
        base1 = int'(word.luma_second) * 65536;
        pair.red_first     = clamp_and_scale(base0 + RED_PER_CR * cr);
        pair.green_first   = clamp_and_scale(base0 - GREEN_PER_CR * cr - GREEN_PER_CB * cb);
        pair.blue_first    = clamp_and_scale(base0 + BLUE_PER_CB * cb);
        pair.red_second    = clamp_and_scale(base1 + RED_PER_CR * cr);
        pair.green_second  = clamp_and_scale(base1 - GREEN_PER_CR * cr - GREEN_PER_CB * cb);
        pair.blue_second   = clamp_and_scale(base1 + BLUE_PER_CB * cb);
        pair.frame_end_out = word.frame_end;
        return pair;
    endfunction

    task automatic queue_word(int y0, int cb, int y1, int cr, bit fe);
        yuy2_in_t word;
        word.luma_first  = 8'(y0);
        word.chroma_blue = 8'(cb);
        word.luma_second = 8'(y1);
        word.chroma_red  = 8'(cr);
        word.frame_end   = fe;
        yuy2_words.push_back(word);
    endtask

    task automatic report_mismatch(string field, int got, int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("result %0d: %s got %0d expected %0d", result_count, field, got, want);
        end
    endtask

    function automatic int chroma_sample();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom_range(0, 15);
            2, 3:    return $urandom_range(240, 255);
            4:       return $urandom_range(120, 136);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // stimulus, reset and end of run
    initial begin
        int frame_left;
        queue_word(0, 0, 0, 0, 1'b0);
        queue_word(255, 255, 255, 255, 1'b1);
        queue_word(0, 128, 255, 128, 1'b0);
        queue_word(1, 128, 254, 128, 1'b0);
        queue_word(127, 128, 128, 128, 1'b1);
        queue_word(0, 0, 255, 255, 1'b0);
        queue_word(255, 255, 0, 0, 1'b0);
        queue_word(0, 128, 0, 255, 1'b0);
        queue_word(255, 128, 255, 0, 1'b0);
        queue_word(0, 255, 0, 128, 1'b0);
        queue_word(255, 0, 255, 128, 1'b0);
        queue_word(255, 0, 255, 0, 1'b0);
        queue_word(0, 255, 0, 255, 1'b0);
        queue_word(170, 85, 85, 170, 1'b1);
        queue_word(85, 170, 170, 85, 1'b0);
        queue_word(235, 128, 16, 128, 1'b0);
        queue_word(200, 128, 60, 200, 1'b0);
        queue_word(200, 200, 60, 128, 1'b0);
        queue_word(40, 60, 220, 60, 1'b0);
        queue_word(16, 90, 240, 240, 1'b1);
        frame_left = $urandom_range(1, 40);
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            frame_left--;
            if ($urandom_range(0, 4) == 0) begin
                queue_word(chroma_sample(), chroma_sample(), chroma_sample(), chroma_sample(),
                           frame_left <= 0);
            end else begin
                queue_word($urandom_range(0, 255), chroma_sample(), $urandom_range(0, 255),
                           chroma_sample(), frame_left <= 0);
            end
            if (frame_left <= 0) begin
                frame_left = $urandom_range(1, 40);
            end
        end

        repeat (10) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        while (yuy2_words.size() != 0 || s_valid || rgb_expected.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // request driver and result-side stall pattern
    always @(negedge aclk) begin
        bit take_next;
        bit ready_next;
        if (aresetn) begin
            take_next = !s_valid || req_accepted;
            if (take_next) begin
                if (gap_left > 0 || yuy2_words.size() == 0) begin
                    s_valid <= 1'b0;
                    if (gap_left > 0) begin
                        gap_left--;
                    end
                end else begin
                    s_data  <= yuy2_words.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end

            ready_tick++;
            if (ready_tick % 40 == 0) begin
                ready_mode = $urandom_range(0, 3);
            end
            case (ready_mode)
                0:       ready_next = 1'b1;
                1:       ready_next = 1'($urandom_range(0, 1));
                2:       ready_next = (ready_tick % 5) != 0;
                default: ready_next = (ready_tick % 16) >= 12;
            endcase
            m_ready <= ready_next;
        end
    end

    // request capture and result checking
    always @(posedge aclk) begin
        rgb_pair_t want;
        if (aresetn) begin
            req_accepted = s_valid && s_ready;
            if (req_accepted) begin
                rgb_expected.push_back(convert_yuy2_pair(s_data));
            end
            if (m_valid && m_ready) begin
                if (rgb_expected.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    want = rgb_expected.pop_front();
                    if (m_data.red_first !== want.red_first)
                        report_mismatch("red_first", int'(m_data.red_first),
                                        int'(want.red_first));
                    if (m_data.green_first !== want.green_first)
                        report_mismatch("green_first", int'(m_data.green_first),
                                        int'(want.green_first));
                    if (m_data.blue_first !== want.blue_first)
                        report_mismatch("blue_first", int'(m_data.blue_first),
                                        int'(want.blue_first));
                    if (m_data.red_second !== want.red_second)
                        report_mismatch("red_second", int'(m_data.red_second),
                                        int'(want.red_second));
                    if (m_data.green_second !== want.green_second)
                        report_mismatch("green_second", int'(m_data.green_second),
                                        int'(want.green_second));
                    if (m_data.blue_second !== want.blue_second)
                        report_mismatch("blue_second", int'(m_data.blue_second),
                                        int'(want.blue_second));
                    if (m_data.frame_end_out !== want.frame_end_out)
                        report_mismatch("frame_end_out", int'(m_data.frame_end_out),
                                        int'(want.frame_end_out));
                end
                result_count++;
            end
        end else begin
            req_accepted = 1'b0;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
